// ===== hdl/pvaa_pkg.sv =====
// Shared widths, operation and register codes, and the element mask function.
`default_nettype none

package pvaa_pkg;

    localparam int DATA_W    = 64;
    localparam int INDEX_W   = 16;
    localparam int WIDTH_W   = 7;
    localparam int COUNT_W   = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int BITPOS_W  = 22;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT  = 1'b1;

    localparam logic [WIDTH_W-1:0] BITS_PER_VALUE_RST = 7'd8;

    typedef logic [DATA_W-1:0] t_data;

    // Mask of the low w bits; w is never above 64 where this is used.
    function automatic t_data width_mask(input logic [WIDTH_W-1:0] w);
        t_data m;
        if (w >= 7'd64) begin
            m = '1;
        end else begin
            m = (t_data'(1) << w) - t_data'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/packed_varbit_array_access_unit.sv =====
// Top level: bit-packed unsigned integer array held in one 64-bit word memory.
`default_nettype none

// A request is taken when start is high and busy is low; its result appears on
// o_read_value and o_index_error for one cycle with o_valid high. A request whose
// index is out of range, or any request while the element width is zero, returns
// its result in the cycle after acceptance and leaves busy low, so such requests
// may follow one another every cycle. Any other request keeps busy high through
// the index-to-word reduction (a reciprocal multiply, a remainder and a
// correction), then two reads of the word memory, then, for a write, one
// write-back, or two for an element that straddles two words. A new request
// may be issued in the cycle the result shows.
// The result cannot be held off; it must be taken when o_valid is high.
module packed_varbit_array_access_unit #(
    parameter int STORE_WORDS    = 1024,
    parameter int MAX_VALUE_BITS = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_func,
    input  wire logic [pvaa_pkg::INDEX_W-1:0]     i_index,
    input  wire logic [pvaa_pkg::DATA_W-1:0]      i_write_value,
    input  wire logic                             i_cfg_we,
    input  wire logic [pvaa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pvaa_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                                  o_valid,
    output logic [pvaa_pkg::DATA_W-1:0]           o_read_value,
    output logic                                  o_index_error
);
    import pvaa_pkg::*;

    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_VALUE_BITS);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / STORE_WORDS);
    localparam logic [INDEX_W:0] SW = (INDEX_W + 1)'(STORE_WORDS);
    localparam logic [AW-1:0] LAST = AW'(STORE_WORDS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_DIV3 = 3'd3;
    localparam logic [2:0] S_RD0  = 3'd4;
    localparam logic [2:0] S_RD1  = 3'd5;
    localparam logic [2:0] S_RD2  = 3'd6;
    localparam logic [2:0] S_WR1  = 3'd7;

    logic [WIDTH_W-1:0]  r_bits_per_value;
    logic [COUNT_W-1:0]  r_element_count;
    logic [2:0]          r_state;
    logic [2:0]          n_state;

    logic                r_func;
    logic [WIDTH_W-1:0]  r_width;
    t_data               r_wval;
    logic [BITPOS_W-1:0] r_bitpos;
    logic [INDEX_W-1:0]  r_q;
    logic [INDEX_W+1:0]  r_rem;
    logic [AW-1:0]       r_word;
    logic [AW-1:0]       r_next;
    t_data               r_rdata;
    t_data               r_lo;
    t_data               r_new_hi;
    t_data               r_mem [STORE_WORDS];

    logic                r_valid;
    t_data               r_read_value;
    logic                r_index_error;

    logic                accept;
    logic                idx_err;
    logic [WIDTH_W-1:0]  eff_w;
    logic                fast_path;
    logic [48:0]         q_prod;
    logic [32:0]         qs_prod;
    logic [32:0]         rem_full;
    logic [INDEX_W+1:0]  word_full;
    logic [AW-1:0]       word_red;
    t_data               w_mask;
    logic [5:0]          off;
    logic [6:0]          rshift;
    logic                straddle;
    t_data               rd_val;
    t_data               new_lo;
    t_data               hi_base;
    t_data               new_hi;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_data               mem_wdata;
    logic [AW-1:0]       mem_raddr;

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_read_value  = r_read_value;
    assign o_index_error = r_index_error;

    assign accept    = start && !busy;
    assign idx_err   = ({1'b0, i_index} >= r_element_count);
    assign eff_w     = (r_bits_per_value > MAX_W) ? MAX_W : r_bits_per_value;
    assign fast_path = idx_err || (eff_w == '0);

    // Word index reduced modulo the store size: the reciprocal estimate is at
    // most one short, so a single compare and subtract finishes it.
    assign q_prod    = 49'(r_bitpos[BITPOS_W-1:6]) * 49'(RECIP);
    assign qs_prod   = 33'(r_q) * 33'(SW);
    assign rem_full  = 33'(r_bitpos[BITPOS_W-1:6]) - qs_prod;
    assign word_full = (r_rem >= (INDEX_W + 2)'(SW)) ? r_rem - (INDEX_W + 2)'(SW) : r_rem;
    assign word_red  = word_full[AW-1:0];

    assign w_mask   = width_mask(r_width);
    assign off      = r_bitpos[5:0];
    assign rshift   = 7'd64 - {1'b0, off};
    assign straddle = ({2'b00, off} + {1'b0, r_width}) > 8'd64;

    assign rd_val = ((r_lo >> off) | (straddle ? (r_rdata << rshift) : '0)) & w_mask;
    assign new_lo = (r_lo & ~(w_mask << off)) | (r_wval << off);
    // With a one-word store both halves land in the same word, so the second
    // merge must start from the first one's result.
    assign hi_base = (r_word == r_next) ? new_lo : r_rdata;
    assign new_hi  = (hi_base & ~(w_mask >> rshift)) | (r_wval >> rshift);

    assign mem_we    = ((r_state == S_RD2) && (r_func == FUNC_WRITE)) || (r_state == S_WR1);
    assign mem_waddr = (r_state == S_WR1) ? r_next : r_word;
    assign mem_wdata = (r_state == S_WR1) ? r_new_hi : new_lo;
    assign mem_raddr = (r_state == S_RD1) ? r_next : r_word;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !fast_path) begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1: n_state = S_DIV2;
            S_DIV2: n_state = S_DIV3;
            S_DIV3: n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2: begin
                if ((r_func == FUNC_WRITE) && straddle) begin
                    n_state = S_WR1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WR1:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_valid          <= 1'b0;
            r_bits_per_value <= BITS_PER_VALUE_RST;
            r_element_count  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (accept && fast_path)
                    || ((r_state == S_RD2) && !((r_func == FUNC_WRITE) && straddle))
                    || (r_state == S_WR1);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BITS_PER_VALUE: r_bits_per_value <= i_cfg_wdata[WIDTH_W-1:0];
                    CFG_ELEMENT_COUNT:  r_element_count  <= i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func        <= i_func;
            r_width       <= eff_w;
            r_wval        <= i_write_value & width_mask(eff_w);
            r_bitpos      <= BITPOS_W'(i_index) * BITPOS_W'(eff_w);
            r_read_value  <= '0;
            r_index_error <= idx_err;
        end
        if (r_state == S_DIV1) begin
            r_q <= q_prod[47:32];
        end
        if (r_state == S_DIV2) begin
            r_rem <= rem_full[INDEX_W+1:0];
        end
        if (r_state == S_DIV3) begin
            r_word <= word_red;
            r_next <= (word_red == LAST) ? '0 : word_red + AW'(1);
        end
        if (r_state == S_RD1) begin
            r_lo <= r_rdata;
        end
        if (r_state == S_RD2) begin
            r_new_hi     <= new_hi;
            r_read_value <= (r_func == FUNC_READ) ? rd_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

`ifndef SYNTH
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted request neither answered nor in progress");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a request is still in progress");

    a_write_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_func == FUNC_WRITE))
        else $error("memory written during a read request");

    a_second_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR1) |-> ($past(r_state) == S_RD2))
        else $error("upper word written without the lower word first");
`endif

endmodule

`default_nettype wire
